// File: hw/rtl/nfha_pkg.sv
// Package for the next-fit handle allocator: sizes, command and status codes,
// stream word layout and the find-first-free helper.
// Depends on nothing; the top level imports it.
package nfha_pkg;

  localparam int NUM_HANDLES = 1024;
  localparam int HANDLE_W    = $clog2(NUM_HANDLES);
  localparam int HANDLE_IN_W = 10;
  localparam int CAP_W       = 32;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int NUM_ROWS    = NUM_HANDLES / WORD_W;
  localparam int ROW_W       = HANDLE_W - BIT_W;

  localparam int IN_W        = CMD_W + HANDLE_IN_W + CAP_W;
  localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = HANDLE_IN_W + CAP_W + STATUS_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_ABANDON = 2'd1,
    CMD_COPY    = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: hw/rtl/nfha_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the in-use bitmap and the capacity table; no dependencies.
module nfha_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/next_fit_handle_allocator_unit.sv
// Top level of the next-fit handle allocator: command sequencer, bitmap and
// capacity memories, and the result register. Depends on nfha_pkg and nfha_ram.
//
// After reset the block clears the whole capacity table and the in-use bitmap
// and accepts no word until that pass is done. The bitmap is held as 32 rows of
// 32 bits in a memory with a registered read; allocate reads one row, checks it,
// and moves on, from the row under the search pointer until a free slot is
// found or that row has been revisited. Abandon, copy and load read once and
// write back at most once; an abandon of slot 0 or any out-of-range handle is
// answered at once as invalid. Commands are handled one at a time; a result
// waits in the output register while the next command is already being
// processed.
module next_fit_handle_allocator_unit
  import nfha_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // cmd[1:0], handle_in[11:2], capacity_in[43:12], zero fill above
  input  logic [IN_BYTES_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // handle_out[9:0], capacity_out[41:10], status[43:42], zero fill above
  output logic [OUT_BYTES_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_RD, S_WB, S_OUT
  } state_t;

  state_t                 state;
  cmd_t                   cmd_q;
  logic [HANDLE_IN_W-1:0] hdl_q;
  logic [CAP_W-1:0]       cap_q;
  logic [HANDLE_W-1:0]    ptr;
  logic [ROW_W:0]         step;
  logic [ROW_W-1:0]       row;
  logic [HANDLE_W-1:0]    clr_cnt;
  logic [HANDLE_IN_W-1:0] res_handle;
  logic [CAP_W-1:0]       res_cap;
  status_t                res_status;

  logic                bm_we, bm_re, cap_we, cap_re;
  logic [ROW_W-1:0]    bm_waddr, bm_raddr;
  logic [WORD_W-1:0]   bm_wdata, bm_rdata;
  logic [HANDLE_W-1:0] cap_waddr, cap_raddr;
  logic [CAP_W-1:0]    cap_wdata, cap_rdata;

  cmd_t                   in_cmd;
  logic [HANDLE_IN_W-1:0] in_hdl;
  logic [CAP_W-1:0]       in_cap;
  logic                   in_range;
  logic [HANDLE_W-1:0]    hdl_addr;
  logic [ROW_W-1:0]       hdl_row;
  logic [BIT_W-1:0]       hdl_bit;
  logic [BIT_W-1:0]       ptr_bit;
  logic [WORD_W-1:0]      hi_mask;
  logic [WORD_W-1:0]      scan_mask;
  logic [WORD_W-1:0]      free_w;
  logic                   found;
  logic [BIT_W-1:0]       found_bit;
  logic [HANDLE_W-1:0]    slot;

  assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
  assign in_hdl   = s_tdata[CMD_W +: HANDLE_IN_W];
  assign in_cap   = s_tdata[CMD_W + HANDLE_IN_W +: CAP_W];
  assign in_range = 32'(in_hdl) < 32'(NUM_HANDLES);

  assign hdl_addr = hdl_q[HANDLE_W-1:0];
  assign hdl_row  = hdl_addr[HANDLE_W-1:BIT_W];
  assign hdl_bit  = hdl_addr[BIT_W-1:0];
  assign ptr_bit  = ptr[BIT_W-1:0];
  assign hi_mask  = {WORD_W{1'b1}} << ptr_bit;

  // The first row visited keeps only slots at or above the pointer, the final
  // revisit of that row only slots below it, and slot 0 is never granted.
  always_comb begin
    scan_mask = {WORD_W{1'b1}};
    if (step == '0) begin
      scan_mask = hi_mask;
    end else if (step == (ROW_W + 1)'(NUM_ROWS)) begin
      scan_mask = ~hi_mask;
    end
    if (row == '0) begin
      scan_mask[0] = 1'b0;
    end
  end

  assign free_w    = ~bm_rdata & scan_mask;
  assign found     = |free_w;
  assign found_bit = first_set(free_w);
  assign slot      = {row, found_bit};

  assign s_tready = (state == S_IDLE);

  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = '0;
    bm_wdata  = '0;
    bm_re     = 1'b0;
    bm_raddr  = '0;
    cap_we    = 1'b0;
    cap_waddr = '0;
    cap_wdata = '0;
    cap_re    = 1'b0;
    cap_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        bm_we     = (clr_cnt[HANDLE_W-1:ROW_W] == '0);
        bm_waddr  = clr_cnt[ROW_W-1:0];
        cap_we    = 1'b1;
        cap_waddr = clr_cnt;
      end
      S_SCAN_RD: begin
        bm_re    = 1'b1;
        bm_raddr = row;
      end
      S_SCAN_CHK: begin
        bm_we     = found;
        bm_waddr  = row;
        bm_wdata  = bm_rdata | (WORD_W'(1) << found_bit);
        cap_we    = found;
        cap_waddr = slot;
        cap_wdata = cap_q;
      end
      S_RD: begin
        bm_re     = 1'b1;
        bm_raddr  = (cmd_q == CMD_ABANDON) ? hdl_row : '0;
        cap_re    = 1'b1;
        cap_raddr = hdl_addr;
      end
      S_WB: begin
        case (cmd_q)
          CMD_ABANDON: begin
            bm_we    = 1'b1;
            bm_waddr = hdl_row;
            bm_wdata = bm_rdata & ~(WORD_W'(1) << hdl_bit);
          end
          CMD_COPY: begin
            bm_we     = (hdl_addr != '0);
            bm_wdata  = bm_rdata | WORD_W'(1);
            cap_we    = (hdl_addr != '0);
            cap_wdata = cap_rdata;
          end
          CMD_LOAD: begin
            bm_we     = 1'b1;
            bm_wdata  = bm_rdata | WORD_W'(1);
            cap_we    = 1'b1;
            cap_wdata = cap_q;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      ptr      <= HANDLE_W'(1);
      step     <= '0;
      row      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + HANDLE_W'(1);
          if (clr_cnt == HANDLE_W'(NUM_HANDLES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q <= in_cmd;
            hdl_q <= in_hdl;
            cap_q <= in_cap;
            step  <= '0;
            row   <= ptr[HANDLE_W-1:BIT_W];
            if (in_cmd == CMD_ALLOC) begin
              state <= S_SCAN_RD;
            end else if (!in_range || (in_cmd == CMD_ABANDON && in_hdl == '0)) begin
              res_handle <= in_hdl;
              res_cap    <= '0;
              res_status <= ST_INVALID;
              state      <= S_OUT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (found) begin
            res_handle <= HANDLE_IN_W'(slot);
            res_cap    <= cap_q;
            res_status <= ST_OK;
            ptr        <= (slot == HANDLE_W'(NUM_HANDLES - 1)) ? HANDLE_W'(1)
                                                                : slot + HANDLE_W'(1);
            state      <= S_OUT;
          end else if (step == (ROW_W + 1)'(NUM_ROWS)) begin
            res_handle <= '0;
            res_cap    <= '0;
            res_status <= ST_FULL;
            state      <= S_OUT;
          end else begin
            step  <= step + (ROW_W + 1)'(1);
            row   <= row + ROW_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_RD: begin
          state <= S_WB;
        end
        S_WB: begin
          res_status <= ST_OK;
          res_handle <= (cmd_q == CMD_LOAD) ? '0 : hdl_q;
          res_cap    <= (cmd_q == CMD_LOAD) ? cap_q : cap_rdata;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_BYTES_W'({res_status, res_cap, res_handle});
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  nfha_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  nfha_ram #(
    .WIDTH (CAP_W),
    .DEPTH (NUM_HANDLES)
  ) u_cap (
    .clk   (clk),
    .we    (cap_we),
    .waddr (cap_waddr),
    .wdata (cap_wdata),
    .re    (cap_re),
    .raddr (cap_raddr),
    .rdata (cap_rdata)
  );

endmodule
